// File: hdl/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg - shared types and codes for the tank pump level controller
// Operation, button, buzzer and display codes, plus the item and result
// records passed between the pipeline stages.
// ----------------------------------------------------------------------------
package plc_pkg;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_LEVEL  = 2'd1;
  localparam logic [1:0] OP_FAULT  = 2'd2;
  localparam logic [1:0] OP_BUTTON = 2'd3;

  // Button ids and events
  localparam logic [1:0] BTN_UNBLOCK   = 2'd1;
  localparam logic [1:0] BTN_AUTO      = 2'd2;
  localparam logic [1:0] BEV_PRESS     = 2'd0;
  localparam logic [1:0] BEV_LONG      = 2'd1;

  // Level report patterns
  localparam logic [2:0] LVL_NONE      = 3'd0;
  localparam logic [2:0] LVL_LOW       = 3'd1;
  localparam logic [2:0] LVL_UNDER_MID = 3'd2;

  // Buzzer commands
  localparam logic [1:0] BUZ_NONE    = 2'd0;
  localparam logic [1:0] BUZ_OFF     = 2'd1;
  localparam logic [1:0] BUZ_ONESHOT = 2'd2;
  localparam logic [1:0] BUZ_BLINK   = 2'd3;

  // Display events
  localparam logic [2:0] DSP_NONE     = 3'd0;
  localparam logic [2:0] DSP_START    = 3'd1;
  localparam logic [2:0] DSP_STOP     = 3'd2;
  localparam logic [2:0] DSP_FAULT    = 3'd3;
  localparam logic [2:0] DSP_CLEARED  = 3'd4;
  localparam logic [2:0] DSP_AUTO_OFF = 3'd5;

  // Run-time limit after reset
  localparam logic [31:0] MAX_RUN_RESET = 32'd600000;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] level_bits;
    logic [1:0] button_id;
    logic [1:0] button_event;
  } plc_item_t;

  typedef struct packed {
    logic       pump_drive;
    logic       pump_led;
    logic       error_led;
    logic [1:0] buzzer_cmd;
    logic [2:0] display_event;
    logic       auto_mode;
  } plc_result_t;

endpackage

// File: hdl/plc_core.sv
// ----------------------------------------------------------------------------
// plc_core - controller state and per-transaction update
// Holds the pump, fault, automatic and lamp flags, the run-time counter and
// the run limit; computes the result of one item and commits it on step.
// ----------------------------------------------------------------------------
module plc_core #(
  parameter int COUNTER_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  logic                step,
  input  plc_pkg::plc_item_t  item,
  output plc_pkg::plc_result_t result
);
  import plc_pkg::*;

  localparam int CMP_BITS = (COUNTER_BITS > 32) ? COUNTER_BITS : 32;

  logic                    pump_running, pump_running_next;
  logic                    fault_latched, fault_latched_next;
  logic                    auto_enabled, auto_enabled_next;
  logic                    pump_lamp, pump_lamp_next;
  logic [COUNTER_BITS-1:0] run_ticks, run_ticks_next;
  logic [31:0]             max_run_ticks;

  logic [COUNTER_BITS-1:0] ticks_inc;
  logic                    overrun;
  logic [1:0]              buz;
  logic [2:0]              dsp;

  // Saturating increment and limit compare
  assign ticks_inc = (run_ticks == {COUNTER_BITS{1'b1}}) ? run_ticks
                   : run_ticks + COUNTER_BITS'(1);
  assign overrun   = CMP_BITS'(ticks_inc) >= CMP_BITS'(max_run_ticks);

  // Decode one item into the next state
  always_comb begin
    pump_running_next  = pump_running;
    fault_latched_next = fault_latched;
    auto_enabled_next  = auto_enabled;
    pump_lamp_next     = pump_lamp;
    run_ticks_next     = run_ticks;
    buz                = BUZ_NONE;
    dsp                = DSP_NONE;
    unique case (item.operation)
      OP_TICK: begin
        if (pump_running) begin
          run_ticks_next = ticks_inc;
          if (overrun && !fault_latched) begin
            fault_latched_next = 1'b1;
            pump_running_next  = 1'b0;
            pump_lamp_next     = 1'b0;
            run_ticks_next     = '0;
            buz                = BUZ_BLINK;
            dsp                = DSP_FAULT;
          end
        end
      end
      OP_LEVEL: begin
        if (!fault_latched) begin
          if (item.level_bits == LVL_LOW || item.level_bits == LVL_UNDER_MID) begin
            if (!pump_running && auto_enabled) begin
              pump_running_next = 1'b1;
              run_ticks_next    = '0;
              pump_lamp_next    = 1'b1;
              buz               = BUZ_ONESHOT;
              dsp               = DSP_START;
            end
          end else if (item.level_bits != LVL_NONE) begin
            if (pump_running) begin
              pump_running_next = 1'b0;
              run_ticks_next    = '0;
              pump_lamp_next    = 1'b0;
              buz               = BUZ_ONESHOT;
              dsp               = DSP_STOP;
            end
          end
        end
      end
      OP_FAULT: begin
        if (!fault_latched) begin
          fault_latched_next = 1'b1;
          pump_running_next  = 1'b0;
          pump_lamp_next     = 1'b0;
          run_ticks_next     = '0;
          buz                = BUZ_BLINK;
          dsp                = DSP_FAULT;
        end
      end
      OP_BUTTON: begin
        if (item.button_id == BTN_AUTO) begin
          if (item.button_event == BEV_PRESS) begin
            auto_enabled_next = 1'b1;
            pump_lamp_next    = 1'b1;
          end else begin
            auto_enabled_next = 1'b0;
            pump_running_next = 1'b0;
            run_ticks_next    = '0;
            pump_lamp_next    = 1'b0;
            dsp               = DSP_AUTO_OFF;
          end
        end else if (item.button_id == BTN_UNBLOCK && item.button_event == BEV_LONG) begin
          if (fault_latched) begin
            fault_latched_next = 1'b0;
            buz                = BUZ_OFF;
            dsp                = DSP_CLEARED;
          end
        end
      end
    endcase
  end

  // Result as seen after this item
  always_comb begin
    result.pump_drive    = pump_running_next;
    result.pump_led      = pump_lamp_next;
    result.error_led     = fault_latched_next;
    result.buzzer_cmd    = buz;
    result.display_event = dsp;
    result.auto_mode     = auto_enabled_next;
  end

  // Commit state on step; limit register on config write
  always_ff @(posedge clk) begin
    if (rst) begin
      pump_running  <= 1'b0;
      fault_latched <= 1'b0;
      auto_enabled  <= 1'b0;
      pump_lamp     <= 1'b0;
      run_ticks     <= '0;
      max_run_ticks <= MAX_RUN_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_run_ticks <= cfg_wr_data;
      end
      if (step) begin
        pump_running  <= pump_running_next;
        fault_latched <= fault_latched_next;
        auto_enabled  <= auto_enabled_next;
        pump_lamp     <= pump_lamp_next;
        run_ticks     <= run_ticks_next;
      end
    end
  end

endmodule

// File: hdl/pump_level_controller.sv
// ----------------------------------------------------------------------------
// pump_level_controller - tank pump level controller
// Takes ticks, level reports, fault reports and button events; drives the
// pump, its lamp, the fault lamp, the buzzer and display events.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    operation, level_bits,
//                                             button_id, button_event
//   out       output     out_valid/out_ready  pump_drive, pump_led, error_led,
//                                             buzzer_cmd, display_event,
//                                             auto_mode
//   cfg       input      cfg_wr_en            cfg_wr_data (max_run_ticks)
//
// One transaction per cycle sustained while out_ready holds. An accepted
// transaction is held in the input register, and the update logic loads the
// result register from it once the result register can take it.
// Synchronous reset clears all flags and the run counter and sets the run
// limit to 600000; no clearing pass. A stalled output holds the result
// register, and the input register stalls behind it.
// ----------------------------------------------------------------------------
module pump_level_controller #(
  parameter int COUNTER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [2:0]  level_bits,
  input  logic [1:0]  button_id,
  input  logic [1:0]  button_event,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pump_drive,
  output logic        pump_led,
  output logic        error_led,
  output logic [1:0]  buzzer_cmd,
  output logic [2:0]  display_event,
  output logic        auto_mode
);
  import plc_pkg::*;

  plc_item_t   item;
  logic        item_valid;
  plc_result_t core_result;
  plc_result_t result;
  logic        advance;

  // Move the held item forward when the result register can take it
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{operation:    operation,
                level_bits:   level_bits,
                button_id:    button_id,
                button_event: button_event};
    end
  end

  plc_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (advance),
    .item        (item),
    .result      (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

  assign pump_drive    = result.pump_drive;
  assign pump_led      = result.pump_led;
  assign error_led     = result.error_led;
  assign buzzer_cmd    = result.buzzer_cmd;
  assign display_event = result.display_event;
  assign auto_mode     = result.auto_mode;

endmodule

// File: hdl/plc_checker.sv
// ----------------------------------------------------------------------------
// plc_checker - port-level checks for the pump level controller
// Watches the result channel for consistency of events and flags.
// ----------------------------------------------------------------------------
module plc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       pump_drive,
  input logic       pump_led,
  input logic       error_led,
  input logic [1:0] buzzer_cmd,
  input logic [2:0] display_event,
  input logic       auto_mode
);
  import plc_pkg::*;

  // A running pump needs automatic mode and no latched fault
  a_run_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && pump_drive |-> auto_mode && !error_led)
    else $error("pump runs without automatic mode or with a fault");

  // A start turns the pump and lamp on with a one-shot beep
  a_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && display_event == DSP_START |->
      pump_drive && pump_led && buzzer_cmd == BUZ_ONESHOT)
    else $error("start event with inconsistent outputs");

  // A fault stop leaves the fault latched and the pump off, buzzer blinking
  a_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && display_event == DSP_FAULT |->
      error_led && !pump_drive && !pump_led && buzzer_cmd == BUZ_BLINK)
    else $error("fault event with inconsistent outputs");

  // Automatic off drops the mode, pump and lamp
  a_auto_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && display_event == DSP_AUTO_OFF |->
      !auto_mode && !pump_drive && !pump_led)
    else $error("automatic off with inconsistent outputs");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(display_event) &&
      $stable(error_led) && $stable(pump_drive))
    else $error("stalled result changed");

endmodule

bind pump_level_controller plc_checker u_plc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pump_drive    (pump_drive),
  .pump_led      (pump_led),
  .error_led     (error_led),
  .buzzer_cmd    (buzzer_cmd),
  .display_event (display_event),
  .auto_mode     (auto_mode)
);

// File: bench/pump_level_checker.sv
// ----------------------------------------------------------------------------
// pump_level_checker - result predictor and comparator for the pump controller
// Watches the input, result and configuration ports of the block. Every
// accepted input transaction is run through a local copy of the controller
// state to work out the result it must cause. Every accepted result
// transaction is compared field by field with the oldest outstanding
// expectation. Hands the failure count and the number of outstanding results
// to the bench top.
// ----------------------------------------------------------------------------
module pump_level_checker #(
  parameter int COUNTER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [2:0]  level_bits,
  input  logic [1:0]  button_id,
  input  logic [1:0]  button_event,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        pump_drive,
  input  logic        pump_led,
  input  logic        error_led,
  input  logic [1:0]  buzzer_cmd,
  input  logic [2:0]  display_event,
  input  logic        auto_mode,
  output int          fail_count,
  output int          pending
);
  import plc_pkg::*;

  // Local copy of the controller state and its run limit
  logic                    running;
  logic                    faulted;
  logic                    auto_on;
  logic                    lamp;
  logic [COUNTER_BITS-1:0] run_count;
  logic [31:0]             run_limit;

  plc_result_t awaited_results[$];
  int          fails = 0;

  // Latch a fault unless one is already latched
  function automatic void trip_fault(inout logic [1:0] buz, inout logic [2:0] dsp);
    if (!faulted) begin
      faulted   = 1'b1;
      running   = 1'b0;
      lamp      = 1'b0;
      run_count = '0;
      buz       = BUZ_BLINK;
      dsp       = DSP_FAULT;
    end
  endfunction

  // Advance the local state by one transaction and return the result it causes
  function automatic plc_result_t next_outputs(plc_item_t item);
    plc_result_t res;
    logic [1:0]  buz;
    logic [2:0]  dsp;
    buz = BUZ_NONE;
    dsp = DSP_NONE;
    case (item.operation)
      OP_TICK: begin
        if (running) begin
          if (run_count != {COUNTER_BITS{1'b1}})
            run_count = run_count + COUNTER_BITS'(1);
          if (64'(run_count) >= 64'(run_limit))
            trip_fault(buz, dsp);
        end
      end
      OP_LEVEL: begin
        if (!faulted) begin
          if (item.level_bits == LVL_LOW || item.level_bits == LVL_UNDER_MID) begin
            if (!running && auto_on) begin
              running   = 1'b1;
              run_count = '0;
              lamp      = 1'b1;
              buz       = BUZ_ONESHOT;
              dsp       = DSP_START;
            end
          end else if (item.level_bits != LVL_NONE) begin
            if (running) begin
              running   = 1'b0;
              run_count = '0;
              lamp      = 1'b0;
              buz       = BUZ_ONESHOT;
              dsp       = DSP_STOP;
            end
          end
        end
      end
      OP_FAULT: begin
        trip_fault(buz, dsp);
      end
      default: begin
        if (item.button_id == BTN_AUTO) begin
          if (item.button_event == BEV_PRESS) begin
            auto_on = 1'b1;
            lamp    = 1'b1;
          end else begin
            auto_on   = 1'b0;
            running   = 1'b0;
            run_count = '0;
            lamp      = 1'b0;
            dsp       = DSP_AUTO_OFF;
          end
        end else if (item.button_id == BTN_UNBLOCK && item.button_event == BEV_LONG) begin
          if (faulted) begin
            faulted = 1'b0;
            buz     = BUZ_OFF;
            dsp     = DSP_CLEARED;
          end
        end
      end
    endcase
    res.pump_drive    = running;
    res.pump_led      = lamp;
    res.error_led     = faulted;
    res.buzzer_cmd    = buz;
    res.display_event = dsp;
    res.auto_mode     = auto_on;
    return res;
  endfunction

  // Report one field mismatch; X or Z on the port also counts
  function automatic int field_bad(string name, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compare results, queue expectations, track the run limit
  always @(posedge clk) begin
    plc_result_t want;
    if (rst) begin
      running   = 1'b0;
      faulted   = 1'b0;
      auto_on   = 1'b0;
      lamp      = 1'b0;
      run_count = '0;
      run_limit = MAX_RUN_RESET;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with no expectation outstanding");
          fails++;
        end else begin
          want = awaited_results.pop_front();
          fails += field_bad("pump_drive", 3'(want.pump_drive), 3'(pump_drive));
          fails += field_bad("pump_led", 3'(want.pump_led), 3'(pump_led));
          fails += field_bad("error_led", 3'(want.error_led), 3'(error_led));
          fails += field_bad("buzzer_cmd", 3'(want.buzzer_cmd), 3'(buzzer_cmd));
          fails += field_bad("display_event", want.display_event, display_event);
          fails += field_bad("auto_mode", 3'(want.auto_mode), 3'(auto_mode));
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(
          next_outputs({operation, level_bits, button_id, button_event}));
      if (cfg_wr_en)
        run_limit = cfg_wr_data;
    end
    pending    <= awaited_results.size();
    fail_count <= fails;
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb - bench top for the tank pump level controller
// Drives a short directed sequence through every operation and corner of the
// controller, then random transactions under a range of run limits, with
// bursty input traffic, a stalling result receiver and long receiver
// hold-offs. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import plc_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 122;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_LIMIT     = 5000;

  // Codes the package leaves unnamed
  localparam logic [2:0] LVL_HIGH    = 3'd4;
  localparam logic [2:0] LVL_FULL    = 3'd7;
  localparam logic [1:0] BTN_NONE    = 2'd0;
  localparam logic [1:0] BTN_SPARE   = 2'd3;
  localparam logic [1:0] BEV_RELEASE = 2'd2;
  localparam logic [1:0] BEV_UNDEF   = 2'd3;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_wr_en    = 1'b0;
  logic [31:0] cfg_wr_data  = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [1:0]  operation    = OP_TICK;
  logic [2:0]  level_bits   = LVL_NONE;
  logic [1:0]  button_id    = BTN_NONE;
  logic [1:0]  button_event = BEV_PRESS;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic        pump_drive;
  logic        pump_led;
  logic        error_led;
  logic [1:0]  buzzer_cmd;
  logic [2:0]  display_event;
  logic        auto_mode;

  int fail_count;
  int pending;

  int sent_count   = 0;
  int drain_errors = 0;
  int hold_asked   = 0;
  int hold_served  = 0;
  int hold_left    = 0;
  int seg_left     = 0;
  int seg_mode     = 0;
  int burst_left   = 0;

  logic [31:0] run_limits [PHASES];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pump_level_controller #(
    .COUNTER_BITS(32)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .level_bits   (level_bits),
    .button_id    (button_id),
    .button_event (button_event),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pump_drive   (pump_drive),
    .pump_led     (pump_led),
    .error_led    (error_led),
    .buzzer_cmd   (buzzer_cmd),
    .display_event(display_event),
    .auto_mode    (auto_mode)
  );

  pump_level_checker #(
    .COUNTER_BITS(32)
  ) level_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .level_bits   (level_bits),
    .button_id    (button_id),
    .button_event (button_event),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pump_drive   (pump_drive),
    .pump_led     (pump_led),
    .error_led    (error_led),
    .buzzer_cmd   (buzzer_cmd),
    .display_event(display_event),
    .auto_mode    (auto_mode),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Result receiver: segments of steady, coin-flip and sparse readiness,
  // plus long hold-offs on request from the stimulus
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      seg_left = 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_served + 1;
      hold_left   = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 2);
        seg_left = $urandom_range(4, 40);
      end
      seg_left = seg_left - 1;
      case (seg_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one transaction and hold it until the block takes it
  task automatic send_item(input logic [1:0] op, input logic [2:0] lvl,
                           input logic [1:0] bid, input logic [1:0] bev);
    in_valid     <= 1'b1;
    operation    <= op;
    level_bits   <= lvl;
    button_id    <= bid;
    button_event <= bev;
    do
      @(posedge clk);
    while (!in_ready);
    sent_count++;
  endtask

  // Pick a random transaction, weighted toward sequences that run the pump
  task automatic pick_item(output logic [1:0] op, output logic [2:0] lvl,
                           output logic [1:0] bid, output logic [1:0] bev);
    int roll;
    roll = $urandom_range(0, 99);
    op   = OP_TICK;
    lvl  = 3'($urandom_range(0, 7));
    bid  = 2'($urandom_range(0, 3));
    bev  = 2'($urandom_range(0, 3));
    if (roll >= 40 && roll < 65) begin
      op = OP_LEVEL;
      if ($urandom_range(0, 9) < 6)
        lvl = $urandom_range(0, 1) ? LVL_LOW : LVL_UNDER_MID;
    end else if (roll >= 65 && roll < 70) begin
      op = OP_FAULT;
    end else if (roll >= 70 && roll < 82) begin
      op  = OP_BUTTON;
      bid = BTN_AUTO;
      if ($urandom_range(0, 9) < 7)
        bev = BEV_PRESS;
    end else if (roll >= 82 && roll < 94) begin
      op  = OP_BUTTON;
      bid = BTN_UNBLOCK;
      if ($urandom_range(0, 9) < 7)
        bev = BEV_LONG;
    end else if (roll >= 94) begin
      op = OP_BUTTON;
    end
  endtask

  // Send random transactions in bursts with random gaps
  task automatic random_items(input int count);
    logic [1:0] op;
    logic [2:0] lvl;
    logic [1:0] bid;
    logic [1:0] bev;
    int         gap;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      pick_item(op, lvl, bid, bev);
      send_item(op, lvl, bid, bev);
    end
  endtask

  // Idle the input and wait for every outstanding result, then settle
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending != 0) begin
      $error("%0d result transactions never arrived", pending);
      drain_errors++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Write the run limit while the block is idle
  task automatic write_limit(input logic [31:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Main stimulus and verdict
  initial begin
    logic [1:0] op;
    logic [2:0] lvl;
    logic [1:0] bid;
    logic [1:0] bev;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk through the controller at the reset run limit
    send_item(OP_TICK,   LVL_FULL,      BTN_SPARE,   BEV_UNDEF);   // tick while stopped
    send_item(OP_LEVEL,  LVL_LOW,       BTN_NONE,    BEV_PRESS);   // start without automatic
    send_item(OP_BUTTON, LVL_NONE,      BTN_AUTO,    BEV_PRESS);   // automatic on, lamp on
    send_item(OP_LEVEL,  LVL_NONE,      BTN_NONE,    BEV_PRESS);   // hold
    send_item(OP_LEVEL,  LVL_LOW,       BTN_NONE,    BEV_PRESS);   // start
    send_item(OP_LEVEL,  LVL_UNDER_MID, BTN_NONE,    BEV_PRESS);   // start while running
    send_item(OP_TICK,   LVL_NONE,      BTN_NONE,    BEV_PRESS);
    send_item(OP_LEVEL,  LVL_HIGH,      BTN_NONE,    BEV_PRESS);   // stop
    send_item(OP_LEVEL,  LVL_FULL,      BTN_NONE,    BEV_PRESS);   // stop while stopped
    send_item(OP_LEVEL,  LVL_UNDER_MID, BTN_NONE,    BEV_PRESS);   // start
    send_item(OP_FAULT,  LVL_NONE,      BTN_NONE,    BEV_PRESS);   // external fault
    send_item(OP_FAULT,  LVL_NONE,      BTN_NONE,    BEV_PRESS);   // fault while latched
    send_item(OP_LEVEL,  LVL_LOW,       BTN_NONE,    BEV_PRESS);   // level while faulted
    send_item(OP_BUTTON, LVL_NONE,      BTN_UNBLOCK, BEV_PRESS);   // short press, ignored
    send_item(OP_BUTTON, LVL_NONE,      BTN_UNBLOCK, BEV_LONG);    // clear fault
    send_item(OP_BUTTON, LVL_NONE,      BTN_UNBLOCK, BEV_LONG);    // clear without fault
    send_item(OP_BUTTON, LVL_NONE,      BTN_NONE,    BEV_LONG);    // unknown buttons
    send_item(OP_BUTTON, LVL_NONE,      BTN_SPARE,   BEV_PRESS);
    send_item(OP_LEVEL,  LVL_LOW,       BTN_NONE,    BEV_PRESS);   // start
    send_item(OP_BUTTON, LVL_NONE,      BTN_AUTO,    BEV_RELEASE); // automatic off, stop
    send_item(OP_BUTTON, LVL_NONE,      BTN_AUTO,    BEV_UNDEF);   // out-of-range event
    send_item(OP_FAULT,  LVL_NONE,      BTN_NONE,    BEV_PRESS);   // fault while idle
    send_item(OP_BUTTON, LVL_NONE,      BTN_UNBLOCK, BEV_LONG);

    // Smallest run limit: overrun on the first tick of a run
    write_limit(32'd1);
    send_item(OP_BUTTON, LVL_NONE, BTN_AUTO, BEV_PRESS);
    send_item(OP_LEVEL,  LVL_LOW,  BTN_NONE, BEV_PRESS);
    send_item(OP_TICK,   LVL_NONE, BTN_NONE, BEV_PRESS);

    run_limits = '{32'd1, 32'd2, 32'd3, 32'd7, 32'd40, 32'($urandom_range(4, 64)),
                   32'hFFFF_FFFF, MAX_RUN_RESET};

    // Random phases, one run limit each
    for (int p = 0; p < PHASES; p++) begin
      write_limit(run_limits[p]);
      if (p == 1 || p == 5) begin
        // hold the receiver off and keep offering so the block backs up
        hold_asked++;
        for (int k = 0; k < 24; k++) begin
          pick_item(op, lvl, bid, bev);
          send_item(op, lvl, bid, bev);
        end
      end
      random_items(ITEMS_PER_PHASE / 2);
      if (p == 3)
        drain();
      random_items(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
    end
    drain();

    $display("tb: %0d input transactions over %0d run limits, %0d receiver hold-offs",
             sent_count, PHASES + 1, hold_asked);
    if (fail_count == 0 && drain_errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// File: files.f
hdl/plc_pkg.sv
hdl/plc_core.sv
hdl/pump_level_controller.sv
hdl/plc_checker.sv
bench/pump_level_checker.sv
bench/tb.sv
